// ===== rtl/core/rpsc_pkg.sv =====
`timescale 1ns / 1ps

package rpsc_pkg;

  localparam int unsigned RUN_TO_LOCK = 8;
  localparam int unsigned RING_DEPTH  = 256;
  localparam int unsigned IDX_W       = $clog2(RING_DEPTH);
  localparam int unsigned RUN_W       = 4;
  localparam int unsigned TICK_W      = 8;
  localparam int unsigned SUM_W       = TICK_W + 1;
  localparam int unsigned MANCH_W     = 4;

  localparam logic [RUN_W-1:0]   RUN_LOCK_CNT = RUN_W'(RUN_TO_LOCK);
  localparam logic [IDX_W-1:0]   IDX_LAST     = IDX_W'(RING_DEPTH - 1);
  localparam logic [SUM_W-1:0]   LONG_PULSE   = SUM_W'(9'h070);
  localparam logic [SUM_W-1:0]   SHORT_PULSE  = SUM_W'(9'h020);
  localparam logic [SUM_W-1:0]   MATCH_TOL    = SUM_W'(9'd8);
  localparam logic [TICK_W-1:0]  OOK_PERIOD   = TICK_W'(8'h80);
  localparam logic [TICK_W-1:0]  PERIOD_MAX   = '1;
  localparam logic [MANCH_W-1:0] MANCH_MIN    = MANCH_W'(4'd4);
  localparam logic [MANCH_W-1:0] MANCH_MAX    = '1;

  typedef enum logic [1:0] {
    MODE_ASK   = 2'd0,
    MODE_OOK   = 2'd1,
    MODE_MANCH = 2'd2,
    MODE_RAW   = 2'd3
  } mode_e;

  // Pulse after the doubled-phase correction
  typedef struct packed {
    logic [TICK_W-1:0] p0;
    logic [TICK_W-1:0] p1;
    logic [SUM_W-1:0]  d;
  } norm_t;

  typedef struct packed {
    logic              locked;
    mode_e             mode;
    logic [TICK_W-1:0] start_index;
    logic [TICK_W-1:0] period_at_lock;
    logic              manchester_hint;
  } result_t;

  function automatic logic [SUM_W-1:0] absdiff(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ===== rtl/core/rpsc_if.sv =====
`timescale 1ns / 1ps

interface rpsc_pulse_if;
  logic                       valid;
  logic                       ready;
  logic [rpsc_pkg::TICK_W-1:0] low_ticks;
  logic [rpsc_pkg::TICK_W-1:0] high_ticks;

  modport source (output valid, output low_ticks, output high_ticks, input ready);
  modport sink   (input valid, input low_ticks, input high_ticks, output ready);
endinterface

interface rpsc_result_if;
  logic                        valid;
  logic                        ready;
  logic                        locked;
  logic [1:0]                  mode;
  logic [rpsc_pkg::TICK_W-1:0] start_index;
  logic [rpsc_pkg::TICK_W-1:0] period_at_lock;
  logic                        manchester_hint;

  modport source (output valid, output locked, output mode, output start_index,
                  output period_at_lock, output manchester_hint, input ready);
  modport sink   (input valid, input locked, input mode, input start_index,
                  input period_at_lock, input manchester_hint, output ready);
endinterface

// ===== rtl/core/rf_pulse_sync_classifier.sv =====
`timescale 1ns / 1ps

// Pulse-train sync search and modulation classifier.
// A pulse is held in the input stage register and its outcome then goes to the result register; a stall holds both.
// Throughput: one pulse per cycle while the result register is empty or drained; the period
// feedback closes combinationally through the halving test and the run update.
// Reset (rst_ni low, asynchronous): run state, ring index, raw mode and both
// stage valids clear; payload registers keep whatever they held.
module rf_pulse_sync_classifier (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i,
  rpsc_pulse_if.sink   pulse_i,
  rpsc_result_if.source result_o
);

  // Input stage: hold the pulse until the result register can take its outcome
  logic                        in_valid_q, in_valid_d;
  logic [rpsc_pkg::TICK_W-1:0] low_q, high_q;
  logic                        out_valid_q, out_valid_d;
  rpsc_pkg::result_t           res_q, res_w;
  logic                        raw_mode_q;
  logic                        advance_w, take_w, step_w;
  logic [rpsc_pkg::TICK_W-1:0] period_w;
  rpsc_pkg::norm_t             norm_w;

  // Advance whenever the result register is empty or being drained
  assign advance_w     = !out_valid_q || result_o.ready;
  assign pulse_i.ready = !in_valid_q || advance_w;
  assign take_w        = pulse_i.valid && pulse_i.ready;
  assign step_w        = advance_w && in_valid_q;

  assign in_valid_d  = take_w ? 1'b1 : (advance_w ? 1'b0 : in_valid_q);
  assign out_valid_d = advance_w ? in_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      raw_mode_q  <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        raw_mode_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_w) begin
      low_q  <= pulse_i.low_ticks;
      high_q <= pulse_i.high_ticks;
    end
    if (step_w) begin
      res_q <= res_w;
    end
  end

  // Fold doubled phases back toward the running period
  rpsc_pulse_norm u_norm (
    .low_ticks_i  (low_q),
    .high_ticks_i (high_q),
    .period_i     (period_w),
    .norm_o       (norm_w)
  );

  // Update the run and decide on lock as the pulse leaves the input stage
  rpsc_run_track u_track (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step_w),
    .raw_mode_i (raw_mode_q),
    .norm_i     (norm_w),
    .period_o   (period_w),
    .result_o   (res_w)
  );

  assign result_o.valid           = out_valid_q;
  assign result_o.locked          = res_q.locked;
  assign result_o.mode            = res_q.mode;
  assign result_o.start_index     = res_q.start_index;
  assign result_o.period_at_lock  = res_q.period_at_lock;
  assign result_o.manchester_hint = res_q.manchester_hint;

endmodule

// ===== rtl/core/rpsc_pulse_norm.sv =====
`timescale 1ns / 1ps

// Halve long pulses that look like doubled phases
module rpsc_pulse_norm (
  input  logic [rpsc_pkg::TICK_W-1:0] low_ticks_i,
  input  logic [rpsc_pkg::TICK_W-1:0] high_ticks_i,
  input  logic [rpsc_pkg::TICK_W-1:0] period_i,
  output rpsc_pkg::norm_t             norm_o
);

  logic [rpsc_pkg::SUM_W-1:0] p0_w, p1_w, sum_w, tol8_w, tol16_w;
  logic                       half_p0, half_p1, half_both, is_long;

  assign p0_w    = {1'b0, low_ticks_i};
  assign p1_w    = {1'b0, high_ticks_i};
  assign sum_w   = p0_w + p1_w;
  assign tol8_w  = sum_w >> 3;
  assign tol16_w = sum_w >> 4;
  assign is_long = sum_w > rpsc_pkg::LONG_PULSE;

  assign half_p0   = rpsc_pkg::absdiff(p0_w >> 1, p1_w) < tol8_w;
  assign half_p1   = rpsc_pkg::absdiff(p0_w, p1_w >> 1) < tol8_w;
  assign half_both = rpsc_pkg::absdiff(sum_w >> 1, {1'b0, period_i}) < tol16_w;

  always_comb begin
    norm_o.p0 = low_ticks_i;
    norm_o.p1 = high_ticks_i;
    norm_o.d  = sum_w;
    if (is_long) begin
      if (half_p0) begin
        norm_o.p0 = low_ticks_i >> 1;
        norm_o.d  = {1'b0, low_ticks_i >> 1} + p1_w;
      end else if (half_p1) begin
        norm_o.p1 = high_ticks_i >> 1;
        norm_o.d  = p0_w + {1'b0, high_ticks_i >> 1};
      end else if (half_both) begin
        norm_o.p0 = low_ticks_i >> 1;
        norm_o.p1 = high_ticks_i >> 1;
        norm_o.d  = sum_w >> 1;
      end
    end
  end

endmodule

// ===== rtl/core/rpsc_run_track.sv =====
`timescale 1ns / 1ps

// Run state: period, run length, Manchester count, run start, ring index
module rpsc_run_track (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic                        raw_mode_i,
  input  rpsc_pkg::norm_t             norm_i,
  output logic [rpsc_pkg::TICK_W-1:0] period_o,
  output rpsc_pkg::result_t           result_o
);

  logic [rpsc_pkg::TICK_W-1:0]  period_q, period_d;
  logic [rpsc_pkg::RUN_W-1:0]   run_q, run_d;
  logic [rpsc_pkg::MANCH_W-1:0] manch_q, manch_d;
  logic [rpsc_pkg::IDX_W-1:0]   start_q, start_d;
  logic [rpsc_pkg::IDX_W-1:0]   index_q, index_d;

  logic [rpsc_pkg::TICK_W-1:0]  d8_w, moved_w;
  logic                         restart_w, manch_like_w, lock_w;
  rpsc_pkg::mode_e              mode_w;

  assign period_o = period_q;
  assign d8_w     = norm_i.d[rpsc_pkg::TICK_W-1:0];
  assign index_d  = (index_q == rpsc_pkg::IDX_LAST) ? '0 : index_q + 1'b1;

  assign restart_w = (norm_i.d < rpsc_pkg::SHORT_PULSE) || norm_i.d[rpsc_pkg::TICK_W] ||
                     (rpsc_pkg::absdiff(norm_i.d, {1'b0, period_q}) > rpsc_pkg::MATCH_TOL);
  assign manch_like_w = rpsc_pkg::absdiff({1'b0, norm_i.p1}, {1'b0, norm_i.p0}) <
                        (norm_i.d >> 3);
  assign moved_w = (d8_w >= period_q) ? period_q + ((d8_w - period_q) >> 1)
                                      : period_q - ((period_q - d8_w) >> 1);

  always_comb begin
    period_d = moved_w;
    run_d    = run_q + 1'b1;
    manch_d  = manch_q;
    start_d  = start_q;
    if (restart_w) begin
      period_d = norm_i.d[rpsc_pkg::TICK_W] ? rpsc_pkg::PERIOD_MAX : d8_w;
      run_d    = '0;
      manch_d  = '0;
      start_d  = index_q;
    end else if (manch_like_w && (manch_q != rpsc_pkg::MANCH_MAX)) begin
      manch_d = manch_q + 1'b1;
    end

    lock_w = (run_d == rpsc_pkg::RUN_LOCK_CNT);

    if (raw_mode_i)                         mode_w = rpsc_pkg::MODE_RAW;
    else if (period_d > rpsc_pkg::OOK_PERIOD) mode_w = rpsc_pkg::MODE_OOK;
    else if (manch_d > rpsc_pkg::MANCH_MIN) mode_w = rpsc_pkg::MODE_MANCH;
    else                                    mode_w = rpsc_pkg::MODE_ASK;

    result_o = '0;
    if (lock_w) begin
      result_o.locked          = 1'b1;
      result_o.mode            = mode_w;
      result_o.start_index     = rpsc_pkg::TICK_W'(start_d);
      result_o.period_at_lock  = period_d;
      result_o.manchester_hint = (mode_w == rpsc_pkg::MODE_ASK) && (manch_d != '0);
      // Clear the run once reported
      period_d = '0;
      run_d    = '0;
      manch_d  = '0;
      start_d  = index_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= '0;
      run_q    <= '0;
      manch_q  <= '0;
      start_q  <= '0;
      index_q  <= '0;
    end else if (step_i) begin
      period_q <= period_d;
      run_q    <= run_d;
      manch_q  <= manch_d;
      start_q  <= start_d;
      index_q  <= index_d;
    end
  end

endmodule

// ===== rtl/core/rpsc_checker.sv =====
`timescale 1ns / 1ps

module rpsc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        cfg_we_i,
  input logic                        cfg_wdata_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        locked_i,
  input logic [1:0]                  mode_i,
  input logic [rpsc_pkg::TICK_W-1:0] start_index_i,
  input logic [rpsc_pkg::TICK_W-1:0] period_i,
  input logic                        hint_i
);

  logic raw_q, last_lock_q, out_take;

  assign out_take = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q       <= 1'b0;
      last_lock_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        raw_q <= cfg_wdata_i;
      end
      if (out_take) begin
        last_lock_q <= locked_i;
      end
    end
  end

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(locked_i) &&
      $stable(mode_i) && $stable(start_index_i) && $stable(period_i) && $stable(hint_i))
    else $error("result changed while stalled");

  // Unlocked results carry zero fields
  a_unlocked_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !locked_i |-> mode_i == rpsc_pkg::MODE_ASK && start_index_i == '0 &&
      period_i == '0 && !hint_i)
    else $error("unlocked result with non-zero fields");

  // Raw mode decides the raw class, and the hint only goes with ASK
  a_raw_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && locked_i |-> (raw_q == (mode_i == rpsc_pkg::MODE_RAW)) &&
      (!hint_i || mode_i == rpsc_pkg::MODE_ASK))
    else $error("class does not follow raw mode or hint");

  // A lock clears the run, so two locks never follow each other
  a_no_double_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && locked_i |-> !last_lock_q)
    else $error("two consecutive locked results");

endmodule

bind rf_pulse_sync_classifier rpsc_checker u_rpsc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_we_i      (cfg_we_i),
  .cfg_wdata_i   (cfg_wdata_i),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .locked_i      (result_o.locked),
  .mode_i        (result_o.mode),
  .start_index_i (result_o.start_index),
  .period_i      (result_o.period_at_lock),
  .hint_i        (result_o.manchester_hint)
);
